FILE: rtl/h2r_pkg.sv
// Shared widths, constants and payload types for the HSL to RGB converter.
package h2r_pkg;

  localparam int HUE_W   = 10;
  localparam int PCT_W   = 7;
  localparam int CH_W    = 8;

  localparam int HUE_TURN = 360;
  localparam int PCT_MAX  = 100;
  localparam int CH_MAX   = 255;

  // 600000 = 64 * 9375: shift first, then divide by the odd part
  localparam int DIV_SHIFT   = 6;
  localparam int DIV_ODD     = 9375;
  localparam int RECIP_SHIFT = 22;
  localparam int RECIP_M     = (1 << RECIP_SHIFT) / DIV_ODD;

  localparam int HUE_R_W = 9;   // reduced hue 0..359
  localparam int LVL_W   = 14;  // hi/lo helper levels 0..10000
  localparam int FRAC_W  = 6;   // ramp factor 0..60
  localparam int RAMP_W  = 20;  // ramp value 0..600000
  localparam int SCL_W   = 28;  // ramp * 255
  localparam int Y_W     = SCL_W - DIV_SHIFT;
  localparam int PROD_W  = 30;  // Y * RECIP_M

  typedef logic [HUE_W-1:0] hue_t;
  typedef logic [PCT_W-1:0] pct_t;
  typedef logic [CH_W-1:0]  chan_t;

endpackage

FILE: rtl/h2r_if.sv
// Valid/ready channel interfaces for HSL input and RGB output transactions.
interface h2r_hsl_if import h2r_pkg::*; ();
  logic valid;
  logic ready;
  hue_t hue_deg;
  pct_t sat_pct;
  pct_t light_pct;

  modport source (output valid, output hue_deg, output sat_pct, output light_pct,
                  input ready);
  modport sink   (input valid, input hue_deg, input sat_pct, input light_pct,
                  output ready);
endinterface

interface h2r_rgb_if import h2r_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t red;
  chan_t green;
  chan_t blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

FILE: rtl/hsl_to_rgb_integer_core.sv
// HSL to RGB integer converter: six-stage pipeline with per-stage flow control.
// Each accepted input transaction passes through every stage register in order before its output is valid.
// Throughput: one transaction per cycle; each stage holds when the next one is full
// and stalled, so bubbles are squeezed out while the output waits.
// Rate is set by the pipeline registers; the scale/divide is split over stages 4 to 6.
// Reset (rst, synchronous) clears all stage valid bits; payload registers are not reset.
module hsl_to_rgb_integer_core import h2r_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  h2r_hsl_if.sink      pix_in,
  h2r_rgb_if.source    pix_out
);

  localparam int NSTG = 6;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] en;

  // stage 1: reduced hue, clamped percentages
  logic [HUE_R_W-1:0] hue1;
  pct_t               sat1;
  pct_t               lit1;
  // stage 2: helper levels and per-channel ramp factors
  logic [LVL_W-1:0]   hi2;
  logic [LVL_W-1:0]   lo2;
  logic [FRAC_W-1:0]  frac2 [3];
  // stage 3: ramp values
  logic [RAMP_W-1:0]  ramp3 [3];
  // stage 4: scaled and pre-shifted
  logic [Y_W-1:0]     y4 [3];
  // stage 5: reciprocal product
  logic [Y_W-1:0]     y5 [3];
  logic [PROD_W-1:0]  prod5 [3];
  // stage 6: output
  chan_t              rgb6 [3];

  function automatic logic [FRAC_W-1:0] ramp_frac(input logic [HUE_R_W-1:0] h);
    if (h < HUE_R_W'(60))
      return FRAC_W'(h);
    else if (h < HUE_R_W'(180))
      return FRAC_W'(60);
    else if (h < HUE_R_W'(240))
      return FRAC_W'(HUE_R_W'(240) - h);
    else
      return '0;
  endfunction

  // flow control: a stage loads when empty or when its successor loads
  always_comb begin
    en[NSTG-1] = !vld[NSTG-1] || pix_out.ready;
    for (int i = NSTG-2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign pix_in.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= pix_in.valid;
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // stage 1
  logic [HUE_R_W-1:0] hue_mod;
  always_comb begin
    if (pix_in.hue_deg >= HUE_W'(2*HUE_TURN))
      hue_mod = HUE_R_W'(pix_in.hue_deg - HUE_W'(2*HUE_TURN));
    else if (pix_in.hue_deg >= HUE_W'(HUE_TURN))
      hue_mod = HUE_R_W'(pix_in.hue_deg - HUE_W'(HUE_TURN));
    else
      hue_mod = HUE_R_W'(pix_in.hue_deg);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      hue1 <= hue_mod;
      sat1 <= (pix_in.sat_pct > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : pix_in.sat_pct;
      lit1 <= (pix_in.light_pct > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : pix_in.light_pct;
    end
  end

  // stage 2; zero saturation gives hi == lo == 100*L, which is the grey case
  logic [15:0]        hi_w;
  logic [15:0]        lo_w;
  logic [15:0]        lit_x;
  logic [15:0]        sat_x;
  logic [HUE_R_W-1:0] hue_r;
  logic [HUE_R_W-1:0] hue_b;
  always_comb begin
    lit_x = 16'(lit1);
    sat_x = 16'(sat1);
    if (lit1 < PCT_W'(50))
      hi_w = lit_x * (16'd100 + sat_x);
    else
      hi_w = 16'd100 * (lit_x + sat_x) - lit_x * sat_x;
    lo_w  = 16'd200 * lit_x - hi_w;
    hue_r = (hue1 < HUE_R_W'(240)) ? hue1 + HUE_R_W'(120) : hue1 - HUE_R_W'(240);
    hue_b = (hue1 >= HUE_R_W'(120)) ? hue1 - HUE_R_W'(120) : hue1 + HUE_R_W'(240);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      hi2      <= hi_w[LVL_W-1:0];
      lo2      <= lo_w[LVL_W-1:0];
      frac2[0] <= ramp_frac(hue_r);
      frac2[1] <= ramp_frac(hue1);
      frac2[2] <= ramp_frac(hue_b);
    end
  end

  // stage 3: ramp = 60*lo + (hi-lo)*frac
  logic [LVL_W-1:0]  span;
  logic [RAMP_W-1:0] ramp_w [3];
  always_comb begin
    span = hi2 - lo2;
    for (int c = 0; c < 3; c++) begin
      ramp_w[c] = RAMP_W'(lo2) * RAMP_W'(60) + RAMP_W'(span) * RAMP_W'(frac2[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int c = 0; c < 3; c++) ramp3[c] <= ramp_w[c];
    end
  end

  // stage 4: scale by 255, drop the power-of-two part of the divisor
  logic [SCL_W-1:0] scl_w [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      scl_w[c] = SCL_W'(ramp3[c]) * SCL_W'(CH_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int c = 0; c < 3; c++) y4[c] <= scl_w[c][SCL_W-1:DIV_SHIFT];
    end
  end

  // stage 5: reciprocal multiply, estimate is exact or one low
  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int c = 0; c < 3; c++) begin
        y5[c]    <= y4[c];
        prod5[c] <= PROD_W'(y4[c]) * PROD_W'(RECIP_M);
      end
    end
  end

  // stage 6: remainder check and correction
  chan_t          q_est [3];
  logic [Y_W-1:0] rem_w [3];
  chan_t          q_fix [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      q_est[c] = prod5[c][RECIP_SHIFT +: CH_W];
      rem_w[c] = y5[c] - Y_W'(q_est[c]) * Y_W'(DIV_ODD);
      q_fix[c] = (rem_w[c] >= Y_W'(DIV_ODD)) ? q_est[c] + CH_W'(1) : q_est[c];
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int c = 0; c < 3; c++) rgb6[c] <= q_fix[c];
    end
  end

  assign pix_out.valid = vld[NSTG-1];
  assign pix_out.red   = rgb6[0];
  assign pix_out.green = rgb6[1];
  assign pix_out.blue  = rgb6[2];

  // accepted transaction always lands in stage 1
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    pix_in.valid && pix_in.ready |=> vld[0])
    else $error("accepted transaction not captured");

  a_hi_ge_lo: assert property (@(posedge clk) disable iff (rst)
    vld[1] |-> hi2 >= lo2)
    else $error("helper levels out of order");

  a_ramp_range: assert property (@(posedge clk) disable iff (rst)
    vld[2] |-> (ramp3[0] <= RAMP_W'(600000)) && (ramp3[1] <= RAMP_W'(600000))
           && (ramp3[2] <= RAMP_W'(600000)))
    else $error("ramp value out of range");

  a_recip_err: assert property (@(posedge clk) disable iff (rst)
    vld[4] |-> (rem_w[0] < Y_W'(2*DIV_ODD)) && (rem_w[1] < Y_W'(2*DIV_ODD))
           && (rem_w[2] < Y_W'(2*DIV_ODD)))
    else $error("reciprocal estimate off by more than one");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    vld[NSTG-1] && !pix_out.ready |=> vld[NSTG-1] && $stable(rgb6[0])
      && $stable(rgb6[1]) && $stable(rgb6[2]))
    else $error("stalled output changed");

endmodule

FILE: sim/hsl_to_rgb_integer_checker.sv
// Checker for the HSL to RGB core: mirrors the integer conversion and compares outputs.
`timescale 1ns / 100ps

module hsl_to_rgb_integer_checker import h2r_pkg::*; (
  input  logic clk,
  input  logic rst,
  h2r_hsl_if   pix_in,
  h2r_rgb_if   pix_out,
  output int   errors,
  output int   pending
);

  localparam int unsigned RAMP_FULL = 600000;  // 60 * 100 * 100

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_t;

  rgb_t pending_rgb[$];

  // Hue ramp for one channel, scaled by 60
  function automatic int unsigned hue_ramp(int unsigned lo, int unsigned hi, int unsigned h);
    if (h < 60)
      return lo * 60 + (hi - lo) * h;
    else if (h < 180)
      return hi * 60;
    else if (h < 240)
      return lo * 60 + (hi - lo) * (240 - h);
    else
      return lo * 60;
  endfunction

  function automatic chan_t ramp_to_chan(int unsigned lo, int unsigned hi, int unsigned h);
    int unsigned scaled;
    scaled = (hue_ramp(lo, hi, h) * CH_MAX) / RAMP_FULL;
    return scaled[CH_W-1:0];
  endfunction

  function automatic rgb_t hsl_to_rgb(hue_t h_in, pct_t s_in, pct_t l_in);
    int unsigned hue, sat, lit, hi, lo, hr, hb, grey;
    rgb_t px;
    hue = int'(h_in) % HUE_TURN;
    sat = (s_in > PCT_MAX) ? PCT_MAX : s_in;
    lit = (l_in > PCT_MAX) ? PCT_MAX : l_in;
    if (sat == 0) begin
      grey = (lit * CH_MAX) / PCT_MAX;
      px.red   = grey[CH_W-1:0];
      px.green = grey[CH_W-1:0];
      px.blue  = grey[CH_W-1:0];
    end else begin
      if (lit < 50)
        hi = lit * (100 + sat);
      else
        hi = (lit + sat) * 100 - sat * lit;
      lo = lit * 200 - hi;
      hr = (hue < 240) ? hue + 120 : hue - 240;
      hb = (hue >= 120) ? hue - 120 : hue + 240;
      px.red   = ramp_to_chan(lo, hi, hr);
      px.green = ramp_to_chan(lo, hi, hue);
      px.blue  = ramp_to_chan(lo, hi, hb);
    end
    return px;
  endfunction

  always @(posedge clk) begin
    rgb_t exp_px;
    if (!rst) begin
      if (pix_out.valid && pix_out.ready) begin
        if (pending_rgb.size() == 0) begin
          if (errors < 10)
            $display("%0t: unexpected output transaction r=%0d g=%0d b=%0d", $realtime,
                     pix_out.red, pix_out.green, pix_out.blue);
          errors <= errors + 1;
        end else begin
          exp_px = pending_rgb.pop_front();
          if (pix_out.red !== exp_px.red || pix_out.green !== exp_px.green ||
              pix_out.blue !== exp_px.blue) begin
            if (errors < 10)
              $display("%0t: mismatch expected r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                       $realtime, exp_px.red, exp_px.green, exp_px.blue,
                       pix_out.red, pix_out.green, pix_out.blue);
            errors <= errors + 1;
          end
        end
      end
      if (pix_in.valid && pix_in.ready)
        pending_rgb.push_back(hsl_to_rgb(pix_in.hue_deg, pix_in.sat_pct, pix_in.light_pct));
    end
    pending <= pending_rgb.size();
  end

endmodule

FILE: sim/tb_hsl_to_rgb_integer_core.sv
// Testbench top for the HSL to RGB core: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_hsl_to_rgb_integer_core;
  import h2r_pkg::*;

  localparam int NUM_RANDOM  = 800;
  localparam int QUIET_TAIL  = 150;   // last random transactions sent with no idling
  localparam int HOLD_START  = 600;   // cycle at which the receiver holds off
  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN_WAIT  = 20;
  localparam int WDOG_LIMIT  = 1000;

  logic clk = 1'b0;
  logic rst;
  logic gaps_on;
  logic stalls_on;
  int   errors;
  int   pending;
  int   quiet_cycles;

  h2r_hsl_if pix_in ();
  h2r_rgb_if pix_out ();

  hsl_to_rgb_integer_core u_top (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in),
    .pix_out (pix_out)
  );

  hsl_to_rgb_integer_checker u_chk (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in),
    .pix_out (pix_out),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Starts at a posedge, returns at the posedge where the transaction is taken
  task automatic send_pixel(input hue_t hue, input pct_t sat, input pct_t light);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      pix_in.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    pix_in.valid     <= 1'b1;
    pix_in.hue_deg   <= hue;
    pix_in.sat_pct   <= sat;
    pix_in.light_pct <= light;
    do @(posedge clk); while (!pix_in.ready);
  endtask

  // Receiver: random stall bursts, plus one long hold-off to back up the pipeline
  initial begin
    int cyc;
    int idle;
    cyc = 0;
    pix_out.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc == HOLD_START) begin
        pix_out.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        cyc += HOLD_CYCLES;
        pix_out.ready <= 1'b1;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
        idle = $urandom_range(1, 12);
        pix_out.ready <= 1'b0;
        repeat (idle) @(negedge clk);
        cyc += idle;
        pix_out.ready <= 1'b1;
      end else begin
        pix_out.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_LIMIT) begin
        $display("tb_hsl_to_rgb_integer_core failed");
        $finish;
      end
    end
  end

  initial begin
    pct_t sat;
    rst               = 1'b1;
    gaps_on           = 1'b1;
    stalls_on         = 1'b1;
    pix_in.valid      = 1'b0;
    pix_in.hue_deg    = '0;
    pix_in.sat_pct    = '0;
    pix_in.light_pct  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // primaries, secondaries and sector edges
    send_pixel(10'd0,   7'd100, 7'd50);
    send_pixel(10'd60,  7'd100, 7'd50);
    send_pixel(10'd120, 7'd100, 7'd50);
    send_pixel(10'd180, 7'd100, 7'd50);
    send_pixel(10'd240, 7'd100, 7'd50);
    send_pixel(10'd300, 7'd100, 7'd50);
    send_pixel(10'd59,  7'd100, 7'd50);
    send_pixel(10'd239, 7'd80,  7'd30);
    send_pixel(10'd359, 7'd100, 7'd50);
    // hue wrap
    send_pixel(10'd360, 7'd100, 7'd50);
    send_pixel(10'd719, 7'd100, 7'd50);
    send_pixel(10'd720, 7'd60,  7'd40);
    // clamps on saturation and lightness
    send_pixel(10'd1023, 7'd127, 7'd127);
    send_pixel(10'd1000, 7'd101, 7'd99);
    send_pixel(10'd512,  7'd127, 7'd64);
    // grey, black, white
    send_pixel(10'd77,  7'd0,   7'd37);
    send_pixel(10'd200, 7'd0,   7'd127);
    send_pixel(10'd0,   7'd0,   7'd0);
    send_pixel(10'd90,  7'd100, 7'd0);
    send_pixel(10'd150, 7'd50,  7'd100);
    // lightness just either side of the helper split
    send_pixel(10'd30,  7'd100, 7'd49);
    send_pixel(10'd30,  7'd1,   7'd50);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == NUM_RANDOM - QUIET_TAIL) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end
      case ($urandom_range(0, 7))
        0:       sat = '0;
        1:       sat = 7'(PCT_MAX);
        default: sat = 7'($urandom_range(0, 127));
      endcase
      send_pixel(10'($urandom_range(0, 1023)), sat, 7'($urandom_range(0, 127)));
    end
    @(negedge clk);
    pix_in.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("tb_hsl_to_rgb_integer_core passed");
    else
      $display("tb_hsl_to_rgb_integer_core failed");
    $finish;
  end

endmodule
